/* sv/mwsm_pkg.sv */
package mwsm_pkg;

    localparam int W_CMD    = 16;
    localparam int W_RATIO  = 16;
    localparam int W_LIM    = 15;
    localparam int ROT_FRAC = 8;
    localparam int FRAC     = 20;
    localparam int W_LIN    = W_CMD + 2;
    localparam int W_ROT    = W_CMD + W_RATIO + 1;
    localparam int W_SUM    = W_ROT + 1;
    localparam int W_PROD   = W_SUM + W_RATIO;
    localparam int W_WHL    = W_PROD - FRAC;
    localparam int W_MAG    = W_WHL - 1;
    localparam int W_NUM    = W_MAG + W_LIM;
    localparam int N_WHL    = 4;
    localparam int W_IDX    = 2;

    localparam int WHL_FR = 0;
    localparam int WHL_FL = 1;
    localparam int WHL_BL = 2;
    localparam int WHL_BR = 3;

    localparam logic [W_RATIO-1:0] RST_ROTATE = 16'd256;
    localparam logic [W_RATIO-1:0] RST_RPM    = 16'd4096;
    localparam logic [W_LIM-1:0]   RST_MAXRPM = 15'd8000;

    typedef enum logic [W_IDX-1:0] {
        REG_ROTATE = 2'd0,
        REG_RPM    = 2'd1,
        REG_MAXRPM = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [W_RATIO-1:0] rot_gain;
        logic [W_RATIO-1:0] rpm_gain;
        logic [W_LIM-1:0]   max_rpm;
    } cfg_t;

    typedef struct packed {
        logic                             clip;
        logic [W_MAG-1:0]                 den;
        logic [N_WHL-1:0]                 neg;
        logic [N_WHL-1:0][W_MAG-1:0]      rem;
        logic [N_WHL-1:0][W_LIM-1:0]      quo;
        logic [N_WHL-1:0][W_CMD-1:0]      wheel;
    } div_beat_t;

    typedef struct packed {
        logic [N_WHL-1:0][W_CMD-1:0] rpm;
        logic                        clip;
    } out_beat_t;

endpackage

/* sv/mecanum_wheel_speed_mixer.sv */
// channel  | handshake           | payload
// s_       | s_valid / s_ready   | s_speed_fwd, s_speed_side, s_spin_rate (signed 16)
// m_       | m_valid / m_ready   | m_rpm_front_right/left, m_rpm_back_left/right, m_clipped
// cfg_     | cfg_valid/cfg_ready | cfg_index (0 rotate, 1 rpm, 2 max rpm), cfg_data
//
// One command per cycle while s_ready is high; the path runs through 4 mixing and
// multiply stages, 3 limit stages, 15 divider stages (one quotient bit each), output reg.
// Synchronous active-low reset empties the pipe and loads the default ratios.
// A held result fills the skid slot; only then does s_ready drop and the pipe freeze.
module mecanum_wheel_speed_mixer
    import mwsm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [W_CMD-1:0]   s_speed_fwd,
    input  logic [W_CMD-1:0]   s_speed_side,
    input  logic [W_CMD-1:0]   s_spin_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [W_CMD-1:0]   m_rpm_front_right,
    output logic [W_CMD-1:0]   m_rpm_front_left,
    output logic [W_CMD-1:0]   m_rpm_back_left,
    output logic [W_CMD-1:0]   m_rpm_back_right,
    output logic               m_clipped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [W_IDX-1:0]   cfg_index,
    input  logic [W_RATIO-1:0] cfg_data
);
    cfg_t                        cfg_reg;
    logic                        en;
    logic                        mix_valid, lim_valid, p_valid;
    logic [N_WHL-1:0][W_WHL-1:0] wheel;
    div_beat_t                   lim_beat;
    out_beat_t                   p_beat, out_reg, skid_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        skid_valid_reg, skid_valid_next;
    logic                        load_out, load_skid, use_skid;
    logic [N_WHL-1:0]            over_lim;
    logic [W_CMD:0]              omag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_gain <= RST_ROTATE;
            cfg_reg.rpm_gain <= RST_RPM;
            cfg_reg.max_rpm  <= RST_MAXRPM;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ROTATE: cfg_reg.rot_gain <= cfg_data;
                REG_RPM:    cfg_reg.rpm_gain <= cfg_data;
                REG_MAXRPM: cfg_reg.max_rpm  <= cfg_data[W_LIM-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    mwsm_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .speed_fwd  (s_speed_fwd),
        .speed_side (s_speed_side),
        .spin_rate  (s_spin_rate),
        .cfg        (cfg_reg),
        .out_valid  (mix_valid),
        .wheel      (wheel)
    );

    mwsm_limit u_limit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mix_valid),
        .wheel     (wheel),
        .max_rpm   (cfg_reg.max_rpm),
        .out_valid (lim_valid),
        .beat      (lim_beat)
    );

    mwsm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (lim_valid),
        .in_beat   (lim_beat),
        .out_valid (p_valid),
        .out_beat  (p_beat)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        use_skid        = 1'b0;
        if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                use_skid        = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (en && p_valid) begin
            if (!out_valid_next) begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (use_skid) begin
            out_reg <= skid_reg;
        end else if (load_out) begin
            out_reg <= p_beat;
        end
        if (load_skid) begin
            skid_reg <= p_beat;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_rpm_front_right = out_reg.rpm[WHL_FR];
    assign m_rpm_front_left  = out_reg.rpm[WHL_FL];
    assign m_rpm_back_left   = out_reg.rpm[WHL_BL];
    assign m_rpm_back_right  = out_reg.rpm[WHL_BR];
    assign m_clipped         = out_reg.clip;

    always_comb begin
        omag = '0;
        for (int k = 0; k < N_WHL; k++) begin
            omag = out_reg.rpm[k][W_CMD-1] ? ({1'b0, ~out_reg.rpm[k]} + 1'b1)
                                           : {1'b0, out_reg.rpm[k]};
            over_lim[k] = omag > {{(W_CMD-W_LIM+1){1'b0}}, cfg_reg.max_rpm};
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a beat while the output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid slot filled without a held result");

    a_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (over_lim == '0))
        else $error("wheel speed beyond max rpm");

endmodule

/* sv/mwsm_mix.sv */
module mwsm_mix
    import mwsm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [W_CMD-1:0]            speed_fwd,
    input  logic [W_CMD-1:0]            speed_side,
    input  logic [W_CMD-1:0]            spin_rate,
    input  cfg_t                        cfg,
    output logic                        out_valid,
    output logic [N_WHL-1:0][W_WHL-1:0] wheel
);
    localparam int STAGES = 4;

    logic [STAGES-1:0]               valid_reg;
    logic [N_WHL-1:0][W_LIN-1:0]     lin_reg, lin_next;
    logic [W_ROT-1:0]                rot_reg, rot_next;
    logic [N_WHL-1:0][W_SUM-1:0]     sum_reg, sum_next;
    logic [N_WHL-1:0][W_PROD-1:0]    prod_reg, prod_next, adj;
    logic [N_WHL-1:0][W_WHL-1:0]     whl_reg, whl_next;
    logic [W_LIN-1:0]                fwd_x, side_x;

    assign fwd_x  = {{(W_LIN-W_CMD){speed_fwd[W_CMD-1]}}, speed_fwd};
    assign side_x = {{(W_LIN-W_CMD){speed_side[W_CMD-1]}}, speed_side};

    always_comb begin
        lin_next[WHL_FR] = side_x - fwd_x;
        lin_next[WHL_FL] = fwd_x + side_x;
        lin_next[WHL_BL] = fwd_x - side_x;
        lin_next[WHL_BR] = '0 - fwd_x - side_x;
        rot_next = $signed({{(W_ROT-W_CMD){spin_rate[W_CMD-1]}}, spin_rate})
                 * $signed({{(W_ROT-W_RATIO){1'b0}}, cfg.rot_gain});
        for (int k = 0; k < N_WHL; k++) begin
            sum_next[k] = {{(W_SUM-W_LIN-ROT_FRAC){lin_reg[k][W_LIN-1]}}, lin_reg[k],
                           {ROT_FRAC{1'b0}}}
                        + {{(W_SUM-W_ROT){rot_reg[W_ROT-1]}}, rot_reg};
            prod_next[k] = $signed({{(W_PROD-W_SUM){sum_reg[k][W_SUM-1]}}, sum_reg[k]})
                         * $signed({{(W_PROD-W_RATIO){1'b0}}, cfg.rpm_gain});
            // bias negatives so the shift truncates toward zero
            adj[k] = prod_reg[k]
                   + {{(W_PROD-FRAC){1'b0}}, {FRAC{prod_reg[k][W_PROD-1]}}};
            whl_next[k] = adj[k][W_PROD-1:FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lin_reg  <= lin_next;
            rot_reg  <= rot_next;
            sum_reg  <= sum_next;
            prod_reg <= prod_next;
            whl_reg  <= whl_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign wheel     = whl_reg;

endmodule

/* sv/mwsm_limit.sv */
module mwsm_limit
    import mwsm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [N_WHL-1:0][W_WHL-1:0] wheel,
    input  logic [W_LIM-1:0]            max_rpm,
    output logic                        out_valid,
    output div_beat_t                   beat
);
    localparam int STAGES = 3;

    logic [STAGES-1:0]             valid_reg;
    logic [N_WHL-1:0][W_WHL-1:0]   nw;
    logic [N_WHL-1:0][W_MAG-1:0]   mag_reg, mag_next, mag2_reg;
    logic [N_WHL-1:0]              neg_reg, neg2_reg;
    logic [N_WHL-1:0][W_CMD-1:0]   w_reg, w2_reg;
    logic [W_MAG-1:0]              top01, top23, largest_next, largest_reg;
    logic [N_WHL-1:0][W_NUM-1:0]   num;
    div_beat_t                     beat_reg, beat_next;

    always_comb begin
        for (int k = 0; k < N_WHL; k++) begin
            nw[k]       = '0 - wheel[k];
            mag_next[k] = wheel[k][W_WHL-1] ? nw[k][W_MAG-1:0] : wheel[k][W_MAG-1:0];
        end
        top01        = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        top23        = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        largest_next = (top01 > top23) ? top01 : top23;

        beat_next.clip = largest_reg > {{(W_MAG-W_LIM){1'b0}}, max_rpm};
        beat_next.den  = largest_reg;
        beat_next.neg  = neg2_reg;
        for (int k = 0; k < N_WHL; k++) begin
            num[k] = {{W_LIM{1'b0}}, mag2_reg[k]} * {{W_MAG{1'b0}}, max_rpm};
            beat_next.rem[k]   = num[k][W_NUM-1:W_LIM];
            beat_next.quo[k]   = num[k][W_LIM-1:0];
            beat_next.wheel[k] = w2_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N_WHL; k++) begin
                neg_reg[k] <= wheel[k][W_WHL-1];
                w_reg[k]   <= wheel[k][W_CMD-1:0];
            end
            mag_reg     <= mag_next;
            mag2_reg    <= mag_reg;
            neg2_reg    <= neg_reg;
            w2_reg      <= w_reg;
            largest_reg <= largest_next;
            beat_reg    <= beat_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign beat      = beat_reg;

endmodule

/* sv/mwsm_div.sv */
module mwsm_div
    import mwsm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  div_beat_t in_beat,
    output logic      out_valid,
    output out_beat_t out_beat
);
    localparam int STEPS = W_LIM;

    logic [STEPS-1:0] valid_reg;
    div_beat_t        stage_reg  [STEPS];
    div_beat_t        stage_next [STEPS];
    logic [W_CMD-1:0] q16;

    // one restoring quotient bit per lane
    function automatic div_beat_t div_step(input div_beat_t b);
        div_beat_t        r;
        logic [W_MAG:0]   t;
        logic [W_MAG:0]   d;
        logic             ge;
        r = b;
        for (int k = 0; k < N_WHL; k++) begin
            t  = {b.rem[k], b.quo[k][W_LIM-1]};
            ge = t >= {1'b0, b.den};
            d  = t - {1'b0, b.den};
            r.rem[k] = ge ? d[W_MAG-1:0] : t[W_MAG-1:0];
            r.quo[k] = {b.quo[k][W_LIM-2:0], ge};
        end
        return r;
    endfunction

    always_comb begin
        stage_next[0] = div_step(in_beat);
        for (int s = 1; s < STEPS; s++) begin
            stage_next[s] = div_step(stage_reg[s-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    always_comb begin
        q16 = '0;
        out_beat.clip = stage_reg[STEPS-1].clip;
        for (int k = 0; k < N_WHL; k++) begin
            q16 = {{(W_CMD-W_LIM){1'b0}}, stage_reg[STEPS-1].quo[k]};
            if (!stage_reg[STEPS-1].clip) begin
                out_beat.rpm[k] = stage_reg[STEPS-1].wheel[k];
            end else if (stage_reg[STEPS-1].neg[k]) begin
                out_beat.rpm[k] = '0 - q16;
            end else begin
                out_beat.rpm[k] = q16;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];

endmodule

/* test/tb_mecanum_wheel_speed_mixer.sv */
`timescale 1ns / 100ps

module tb_mecanum_wheel_speed_mixer;
    import mwsm_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 40;
    localparam int N_DIRECTED   = 22;
    localparam int N_BLOCKS     = 7;
    localparam int BLOCK_ITEMS  = 100;

    localparam logic [W_IDX-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        int rot;
        int rpm;
        int lim;
    } ratio_set_t;

    typedef struct packed {
        int set_sel;
        int fwd;
        int side;
        int spin;
        int typed;
        int fr;
        int fl;
        int bl;
        int br;
        int clip;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [W_CMD-1:0]   s_speed_fwd;
    logic [W_CMD-1:0]   s_speed_side;
    logic [W_CMD-1:0]   s_spin_rate;
    logic               m_valid;
    logic               m_ready;
    logic [W_CMD-1:0]   m_rpm_front_right;
    logic [W_CMD-1:0]   m_rpm_front_left;
    logic [W_CMD-1:0]   m_rpm_back_left;
    logic [W_CMD-1:0]   m_rpm_back_right;
    logic               m_clipped;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [W_IDX-1:0]   cfg_index;
    logic [W_RATIO-1:0] cfg_data;

    logic [W_RATIO-1:0] rot_q8;
    logic [W_RATIO-1:0] rpm_q12;
    logic [W_LIM-1:0]   max_lim;

    out_beat_t  wheel_rpm_q [$];
    ratio_set_t ratio_sets [8];
    dir_row_t   dir_rows [N_DIRECTED];

    int   mismatches     = 0;
    int   quiet_cycles   = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off_req   = 1'b0;

    mecanum_wheel_speed_mixer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_speed_fwd       (s_speed_fwd),
        .s_speed_side      (s_speed_side),
        .s_spin_rate       (s_spin_rate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rpm_front_right (m_rpm_front_right),
        .m_rpm_front_left  (m_rpm_front_left),
        .m_rpm_back_left   (m_rpm_back_left),
        .m_rpm_back_right  (m_rpm_back_right),
        .m_clipped         (m_clipped),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic out_beat_t mix_wheels(input logic signed [W_CMD-1:0] fwd,
                                             input logic signed [W_CMD-1:0] side,
                                             input logic signed [W_CMD-1:0] spin);
        out_beat_t res;
        longint    rot8;
        longint    peak;
        longint    mag;
        longint    lin [N_WHL];
        longint    w [N_WHL];
        int        i;
        rot8 = longint'(spin) * longint'(rot_q8);
        lin[WHL_FR] = -longint'(fwd) + longint'(side);
        lin[WHL_FL] =  longint'(fwd) + longint'(side);
        lin[WHL_BL] =  longint'(fwd) - longint'(side);
        lin[WHL_BR] = -longint'(fwd) - longint'(side);
        peak = 0;
        for (i = 0; i < N_WHL; i++) begin
            w[i] = ((lin[i] * 256 + rot8) * longint'(rpm_q12)) / 1048576;
            mag = (w[i] < 0) ? -w[i] : w[i];
            if (mag > peak)
                peak = mag;
        end
        res.clip = (peak > longint'(max_lim));
        for (i = 0; i < N_WHL; i++) begin
            if (res.clip)
                w[i] = (w[i] * longint'(max_lim)) / peak;
            res.rpm[i] = w[i][W_CMD-1:0];
        end
        return res;
    endfunction

    function automatic logic [W_CMD-1:0] rand_speed();
        case ($urandom_range(3))
            0: return W_CMD'($urandom());
            1: return W_CMD'($urandom_range(1024) - 512);
            2: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return '0;
                    3: return '1;
                    default: return 16'd1;
                endcase
            end
            default: return W_CMD'($urandom_range(16383) - 8192);
        endcase
    endfunction

    function automatic ratio_set_t rand_ratios();
        ratio_set_t c;
        case ($urandom_range(3))
            0: c.rot = 256;
            1: c.rot = $urandom_range(65535);
            2: c.rot = $urandom_range(1023);
            default: c.rot = $urandom_range(1) ? 65535 : 0;
        endcase
        case ($urandom_range(3))
            0: c.rpm = 4096;
            1: c.rpm = $urandom_range(65535);
            2: c.rpm = $urandom_range(8191);
            default: c.rpm = $urandom_range(1) ? 65535 : 0;
        endcase
        case ($urandom_range(3))
            0: c.lim = $urandom_range(65535);
            1: c.lim = 8000;
            2: c.lim = $urandom_range(255);
            default: begin
                case ($urandom_range(2))
                    0: c.lim = 0;
                    1: c.lim = 1;
                    default: c.lim = 32767;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic string beat_str(input out_beat_t b);
        return $sformatf("fr %0d fl %0d bl %0d br %0d clip %0b",
                         $signed(b.rpm[WHL_FR]), $signed(b.rpm[WHL_FL]),
                         $signed(b.rpm[WHL_BL]), $signed(b.rpm[WHL_BR]), b.clip);
    endfunction

    // cfg_valid is left high; the caller lowers it after the last write
    task automatic write_reg(input logic [W_IDX-1:0] idx, input logic [W_RATIO-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ROTATE: rot_q8  = data;
            REG_RPM:    rpm_q12 = data;
            REG_MAXRPM: max_lim = data[W_LIM-1:0];
            default: ;
        endcase
    endtask

    task automatic load_ratios(input ratio_set_t c);
        write_reg(REG_ROTATE, W_RATIO'(c.rot));
        write_reg(REG_RPM, W_RATIO'(c.rpm));
        write_reg(REG_MAXRPM, W_RATIO'(c.lim));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_cmd(input logic [W_CMD-1:0] fwd, input logic [W_CMD-1:0] side,
                            input logic [W_CMD-1:0] spin, input out_beat_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_speed_fwd  <= fwd;
        s_speed_side <= side;
        s_spin_rate  <= spin;
        do @(posedge aclk); while (!s_ready);
        wheel_rpm_q.push_back(want);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (wheel_rpm_q.size() != 0)
            @(posedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        out_beat_t got;
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            got.rpm[WHL_FR] = m_rpm_front_right;
            got.rpm[WHL_FL] = m_rpm_front_left;
            got.rpm[WHL_BL] = m_rpm_back_left;
            got.rpm[WHL_BR] = m_rpm_back_right;
            got.clip        = m_clipped;
            if (wheel_rpm_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing pending: %s", $realtime,
                             beat_str(got));
            end else begin
                want = wheel_rpm_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: wheel rpm mismatch\n  exp %s\n  got %s", $realtime,
                                 beat_str(want), beat_str(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int               i;
        int               blk;
        int               cur_set;
        dir_row_t         r;
        out_beat_t        want;
        logic [W_CMD-1:0] fwd;
        logic [W_CMD-1:0] side;
        logic [W_CMD-1:0] spin;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_speed_fwd  = '0;
        s_speed_side = '0;
        s_spin_rate  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rot_q8       = RST_ROTATE;
        rpm_q12      = RST_RPM;
        max_lim      = RST_MAXRPM;

        ratio_sets[0] = '{256, 4096, 8000};
        ratio_sets[1] = '{256, 2048, 8000};
        ratio_sets[2] = '{256, 4096, 0};
        ratio_sets[3] = '{0, 0, 32767};
        ratio_sets[4] = '{0, 4096, 32767};
        ratio_sets[5] = '{65535, 65535, 32767};
        ratio_sets[6] = '{65535, 65535, 1};
        ratio_sets[7] = '{256, 4096, 65535};  // top bit of max rpm dropped

        //                 set  fwd     side    spin  typ  fr      fl     bl     br      clip
        dir_rows[0]  = '{0, 0,      0,      0,     1, 0,      0,     0,     0,      0};
        dir_rows[1]  = '{0, 100,    0,      0,     1, -100,   100,   100,   -100,   0};
        dir_rows[2]  = '{0, 0,      100,    0,     1, 100,    100,   -100,  -100,   0};
        dir_rows[3]  = '{0, 0,      0,      100,   1, 100,    100,   100,   100,    0};
        dir_rows[4]  = '{0, 8000,   0,      0,     1, -8000,  8000,  8000,  -8000,  0};
        dir_rows[5]  = '{0, 8001,   0,      0,     1, -8000,  8000,  8000,  -8000,  1};
        dir_rows[6]  = '{0, 32767,  32767,  32767, 0, 0,      0,     0,     0,      0};
        dir_rows[7]  = '{0, -32768, -32768, -32768, 0, 0,     0,     0,     0,      0};
        dir_rows[8]  = '{0, -32768, 32767,  0,     0, 0,      0,     0,     0,      0};
        dir_rows[9]  = '{0, 1234,   -567,   -89,   0, 0,      0,     0,     0,      0};
        dir_rows[10] = '{1, 3,      0,      0,     1, -1,     1,     1,     -1,     0};
        dir_rows[11] = '{1, -3,     0,      0,     1, 1,      -1,    -1,    1,      0};
        dir_rows[12] = '{2, 0,      0,      0,     1, 0,      0,     0,     0,      0};
        dir_rows[13] = '{2, 1,      0,      0,     1, 0,      0,     0,     0,      1};
        dir_rows[14] = '{2, -32768, -32768, -32768, 1, 0,     0,     0,     0,      1};
        dir_rows[15] = '{3, 32767,  -32768, 32767, 1, 0,      0,     0,     0,      0};
        dir_rows[16] = '{4, 10,     20,     32767, 1, 10,     30,    -10,   -30,    0};
        dir_rows[17] = '{5, 32767,  32767,  32767, 0, 0,      0,     0,     0,      0};
        dir_rows[18] = '{5, -32768, -32768, -32768, 0, 0,     0,     0,     0,      0};
        dir_rows[19] = '{5, 1,      -1,     1,     0, 0,      0,     0,     0,      0};
        dir_rows[20] = '{6, 0,      0,      1,     0, 0,      0,     0,     0,      0};
        dir_rows[21] = '{7, 32767,  0,      0,     1, -32767, 32767, 32767, -32767, 0};

        send_idle_pct  = 21;
        recv_stall_pct = 60;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unknown index must leave the reset ratios alone
        write_reg(REG_NONE, 16'h0000);
        cfg_valid <= 1'b0;
        cur_set = 0;

        for (i = 0; i < N_DIRECTED; i++) begin
            r = dir_rows[i];
            if (r.set_sel != cur_set) begin
                drain_results();
                load_ratios(ratio_sets[r.set_sel]);
                cur_set = r.set_sel;
            end
            fwd  = W_CMD'(r.fwd);
            side = W_CMD'(r.side);
            spin = W_CMD'(r.spin);
            if (r.typed != 0) begin
                want.rpm[WHL_FR] = W_CMD'(r.fr);
                want.rpm[WHL_FL] = W_CMD'(r.fl);
                want.rpm[WHL_BL] = W_CMD'(r.bl);
                want.rpm[WHL_BR] = W_CMD'(r.br);
                want.clip        = (r.clip != 0);
            end else begin
                want = mix_wheels(fwd, side, spin);
            end
            send_cmd(fwd, side, spin, want);
        end

        for (blk = 0; blk < N_BLOCKS; blk++) begin
            if (blk < 2) begin
                send_idle_pct  = 21;
                recv_stall_pct = 60;
            end else if (blk < 4) begin
                send_idle_pct  = 60;
                recv_stall_pct = 21;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            drain_results();
            load_ratios(rand_ratios());
            // long receiver hold-off so the pipe backs up into s_ready
            if (blk == 5) begin
                hold_off_req <= 1'b1;
                @(posedge aclk);
                hold_off_req <= 1'b0;
            end
            repeat (BLOCK_ITEMS) begin
                fwd  = rand_speed();
                side = rand_speed();
                spin = rand_speed();
                send_cmd(fwd, side, spin, mix_wheels(fwd, side, spin));
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge aclk);

        if (mismatches == 0 && wheel_rpm_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/mwsm_pkg.sv
sv/mwsm_mix.sv
sv/mwsm_limit.sv
sv/mwsm_div.sv
sv/mecanum_wheel_speed_mixer.sv
test/tb_mecanum_wheel_speed_mixer.sv
